// ===== hw/rtl/odcf_pkg.sv =====
`timescale 1ns / 1ps

package odcf_pkg;

	// Default panel size
	localparam int DEF_PANEL_WIDTH  = 96;
	localparam int DEF_PANEL_HEIGHT = 64;

	// Command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Request opcodes
	localparam logic [3:0] OP_POINT  = 4'd0;
	localparam logic [3:0] OP_LINE   = 4'd1;
	localparam logic [3:0] OP_RECT   = 4'd2;
	localparam logic [3:0] OP_FILL   = 4'd3;
	localparam logic [3:0] OP_CLEAR  = 4'd4;
	localparam logic [3:0] OP_ON     = 4'd5;
	localparam logic [3:0] OP_OFF    = 4'd6;
	localparam logic [3:0] OP_WINDOW = 4'd7;
	localparam logic [3:0] OP_PIXEL  = 4'd8;
	localparam logic [3:0] OP_REMAP  = 4'd9;

	// Controller command bytes
	localparam logic [7:0] CMD_COL_ADDR = 8'h15;
	localparam logic [7:0] CMD_ROW_ADDR = 8'h75;
	localparam logic [7:0] CMD_LINE     = 8'h21;
	localparam logic [7:0] CMD_FILL_EN  = 8'h26;
	localparam logic [7:0] CMD_RECT     = 8'h22;
	localparam logic [7:0] CMD_CLEAR    = 8'h25;
	localparam logic [7:0] CMD_DISP_ON  = 8'hAF;
	localparam logic [7:0] CMD_DISP_OFF = 8'hAE;
	localparam logic [7:0] CMD_REMAP    = 8'hA0;
	localparam logic [7:0] REMAP_ROT0   = 8'h60;
	localparam logic [7:0] REMAP_ROT1   = 8'h70;
	localparam logic [7:0] REMAP_ROT2   = 8'h72;
	localparam logic [7:0] REMAP_ROT3   = 8'h62;

	// Classified request, coordinates already swapped for rotation
	typedef struct packed {
		logic [3:0]  op;
		logic [7:0]  x0;
		logic [7:0]  y0;
		logic [7:0]  x1;
		logic [7:0]  y1;
		logic [15:0] color;
		logic [1:0]  rot;
		logic [3:0]  last_idx;
	} cmd_t;

	// Queue status seen by the top level
	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              full;
	} q_stat_t;

	// Sequencer status seen by the top level
	typedef struct packed {
		logic [3:0] idx;
		logic       pop;
	} back_stat_t;

endpackage

// ===== hw/rtl/odcf_front.sv =====
`timescale 1ns / 1ps

module odcf_front import odcf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  opcode,
	input  logic [7:0]  start_x,
	input  logic [7:0]  start_y,
	input  logic [7:0]  end_x,
	input  logic [7:0]  end_y,
	input  logic [15:0] pixel_color,
	input  logic        q_full,
	output logic        push,
	output cmd_t        push_cmd
);

	logic [1:0] rotation_q;
	logic       op_known;
	logic       swap;
	logic [3:0] last_idx;

	// Rotation register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q <= 2'd0;
		end else if (cfg_wen) begin
			rotation_q <= cfg_wdata;
		end
	end

	// Run length of each request, as index of its final byte
	always_comb begin
		last_idx = 4'd0;
		case (opcode)
			OP_POINT:  last_idx = 4'd7;
			OP_LINE:   last_idx = 4'd7;
			OP_RECT:   last_idx = 4'd12;
			OP_FILL:   last_idx = 4'd12;
			OP_CLEAR:  last_idx = 4'd4;
			OP_ON:     last_idx = 4'd0;
			OP_OFF:    last_idx = 4'd0;
			OP_WINDOW: last_idx = 4'd5;
			OP_PIXEL:  last_idx = 4'd1;
			OP_REMAP:  last_idx = 4'd1;
			default:   last_idx = 4'd0;
		endcase
	end

	// Unused opcodes are taken and dropped: they give no bytes
	assign op_known = opcode inside {[OP_POINT:OP_REMAP]};
	assign swap     = rotation_q[0];
	assign in_ready = !q_full;
	assign push     = in_valid && in_ready && op_known;

	always_comb begin
		push_cmd.op       = opcode;
		push_cmd.x0       = swap ? start_y : start_x;
		push_cmd.y0       = swap ? start_x : start_y;
		push_cmd.x1       = swap ? end_y : end_x;
		push_cmd.y1       = swap ? end_x : end_y;
		push_cmd.color    = pixel_color;
		push_cmd.rot      = rotation_q;
		push_cmd.last_idx = last_idx;
	end

endmodule

// ===== hw/rtl/odcf_queue.sv =====
`timescale 1ns / 1ps

module odcf_queue import odcf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_cmd,
	input  logic    pop,
	output logic    q_valid,
	output cmd_t    q_cmd,
	output q_stat_t q_stat
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign q_valid = count_q != '0;
	assign q_stat.count = count_q;
	assign q_stat.full  = count_q == QCNT_W'(QDEPTH);
	assign do_push = push && !q_stat.full;
	assign do_pop  = pop && q_valid;
	assign q_cmd   = mem_q[rd_ptr_q];

	// Storage, no reset
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/odcf_back.sv =====
`timescale 1ns / 1ps

module odcf_back import odcf_pkg::*; #(
	parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
	parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  cmd_t       q_cmd,
	output back_stat_t stat,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       is_data,
	output logic       last_byte
);

	localparam logic [7:0] WM = 8'(PANEL_WIDTH - 1);
	localparam logic [7:0] HM = 8'(PANEL_HEIGHT - 1);

	logic [3:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       is_data_q;
	logic       last_q;
	logic       advance;
	logic       take;
	logic       at_last;
	logic [7:0] sel_byte;
	logic       sel_data;
	logic [7:0] ch_r;
	logic [7:0] ch_g;
	logic [7:0] ch_b;
	logic [7:0] remap_byte;
	logic       fill;

	// Colour channels, 6 bits each
	assign ch_r = {2'b00, q_cmd.color[15:11], 1'b0};
	assign ch_g = {2'b00, q_cmd.color[10:5]};
	assign ch_b = {2'b00, q_cmd.color[4:0], 1'b0};
	assign fill = q_cmd.op == OP_FILL;

	always_comb begin
		case (q_cmd.rot)
			2'd1:    remap_byte = REMAP_ROT1;
			2'd2:    remap_byte = REMAP_ROT2;
			2'd3:    remap_byte = REMAP_ROT3;
			default: remap_byte = REMAP_ROT0;
		endcase
	end

	// Byte select for the current position in the run
	always_comb begin
		sel_byte = 8'h00;
		sel_data = 1'b0;
		case (q_cmd.op)
			OP_POINT: begin
				case (idx_q)
					4'd0:    sel_byte = CMD_COL_ADDR;
					4'd1:    sel_byte = q_cmd.x0;
					4'd2:    sel_byte = WM;
					4'd3:    sel_byte = CMD_ROW_ADDR;
					4'd4:    sel_byte = q_cmd.y0;
					4'd5:    sel_byte = HM;
					4'd6:    begin sel_byte = q_cmd.color[15:8]; sel_data = 1'b1; end
					default: begin sel_byte = q_cmd.color[7:0]; sel_data = 1'b1; end
				endcase
			end
			OP_LINE: begin
				case (idx_q)
					4'd0:    sel_byte = CMD_LINE;
					4'd1:    sel_byte = q_cmd.x0;
					4'd2:    sel_byte = q_cmd.y0;
					4'd3:    sel_byte = q_cmd.x1;
					4'd4:    sel_byte = q_cmd.y1;
					4'd5:    sel_byte = ch_r;
					4'd6:    sel_byte = ch_g;
					default: sel_byte = ch_b;
				endcase
			end
			OP_RECT, OP_FILL: begin
				case (idx_q)
					4'd0:    sel_byte = CMD_FILL_EN;
					4'd1:    sel_byte = {7'd0, fill};
					4'd2:    sel_byte = CMD_RECT;
					4'd3:    sel_byte = q_cmd.x0;
					4'd4:    sel_byte = q_cmd.y0;
					4'd5:    sel_byte = q_cmd.x1;
					4'd6:    sel_byte = q_cmd.y1;
					4'd7:    sel_byte = ch_r;
					4'd8:    sel_byte = ch_g;
					4'd9:    sel_byte = ch_b;
					4'd10:   sel_byte = fill ? ch_r : 8'h00;
					4'd11:   sel_byte = fill ? ch_g : 8'h00;
					default: sel_byte = fill ? ch_b : 8'h00;
				endcase
			end
			OP_CLEAR: begin
				case (idx_q)
					4'd0:    sel_byte = CMD_CLEAR;
					4'd3:    sel_byte = WM;
					4'd4:    sel_byte = HM;
					default: sel_byte = 8'h00;
				endcase
			end
			OP_ON:  sel_byte = CMD_DISP_ON;
			OP_OFF: sel_byte = CMD_DISP_OFF;
			OP_WINDOW: begin
				case (idx_q)
					4'd0:    sel_byte = CMD_COL_ADDR;
					4'd1:    sel_byte = q_cmd.x0;
					4'd2:    sel_byte = q_cmd.x0 + WM;
					4'd3:    sel_byte = CMD_ROW_ADDR;
					4'd4:    sel_byte = q_cmd.y0;
					default: sel_byte = q_cmd.y0 + HM;
				endcase
			end
			OP_PIXEL: begin
				sel_data = 1'b1;
				sel_byte = (idx_q == 4'd0) ? q_cmd.color[15:8] : q_cmd.color[7:0];
			end
			OP_REMAP: sel_byte = (idx_q == 4'd0) ? CMD_REMAP : remap_byte;
			default: begin
				sel_byte = 8'h00;
				sel_data = 1'b0;
			end
		endcase
	end

	// Output register frees up when empty or when its word is taken
	assign advance = !out_valid_q || out_ready;
	assign take    = advance && q_valid;
	assign at_last = idx_q == q_cmd.last_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else if (take) begin
			idx_q       <= at_last ? 4'd0 : idx_q + 4'd1;
			out_valid_q <= 1'b1;
		end else if (advance) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output word, no reset
	always_ff @(posedge clk) begin
		if (take) begin
			out_byte_q <= sel_byte;
			is_data_q  <= sel_data;
			last_q     <= at_last;
		end
	end

	assign stat.idx  = idx_q;
	assign stat.pop  = take && at_last;
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign is_data   = is_data_q;
	assign last_byte = last_q;

endmodule

// ===== hw/rtl/oled_draw_command_formatter_top.sv =====
// The first byte of a run goes through the command queue and then the output register.
// Throughput: one byte per cycle while out_ready is high and a request is queued; a
// request gives 1 to 13 bytes (13 for rectangles). A two-entry command queue lets
// requests be taken while an earlier run is still going out; unused opcodes are
// taken and give no bytes.
// Reset (arst_n, asynchronous): rotation 0, command queue and output register empty.
`timescale 1ns / 1ps

module oled_draw_command_formatter_top import odcf_pkg::*; #(
	parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
	parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  opcode,
	input  logic [7:0]  start_x,
	input  logic [7:0]  start_y,
	input  logic [7:0]  end_x,
	input  logic [7:0]  end_y,
	input  logic [15:0] pixel_color,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        is_data,
	output logic        last_byte
);

	logic       push;
	cmd_t       push_cmd;
	logic       q_valid;
	cmd_t       q_cmd;
	q_stat_t    q_stat;
	back_stat_t back_stat;

	// Front: rotation, swap, classification
	odcf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.pixel_color(pixel_color),
		.q_full     (q_stat.full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	// Command queue
	odcf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (back_stat.pop),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.q_stat  (q_stat)
	);

	// Back: byte sequencer and output register
	odcf_back #(
		.PANEL_WIDTH (PANEL_WIDTH),
		.PANEL_HEIGHT(PANEL_HEIGHT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.stat     (back_stat),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte (out_byte),
		.is_data  (is_data),
		.last_byte(last_byte)
	);

`ifndef ASSERT_OFF
	// Sequencer only retires a command that the queue holds
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.pop |-> q_valid)
		else $error("command popped from empty queue");

	// A final word waiting at the output leaves the sequencer at the run start
	a_last_idx_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_byte) |-> (back_stat.idx == 4'd0))
		else $error("run index not cleared after final word");

	// A stalled output word freezes the sequencer position
	a_stall_holds_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(back_stat.idx))
		else $error("sequencer moved during output stall");

	// Front is blocked only by a full queue
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (q_stat.count == QCNT_W'(QDEPTH)))
		else $error("front stalled with queue space free");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import odcf_pkg::*;

	localparam logic [7:0] COL_LAST = 8'(DEF_PANEL_WIDTH - 1);
	localparam logic [7:0] ROW_LAST = 8'(DEF_PANEL_HEIGHT - 1);
	// opcodes the block takes but answers with no bytes
	localparam logic [3:0] OP_UNUSED_FIRST = 4'd10;
	localparam logic [3:0] OP_UNUSED_LAST  = 4'd15;
	localparam int RESET_CYCLES   = 11;
	localparam int MAX_WAIT       = 19;
	localparam int HOLD_CYCLES    = 300;
	localparam int TAIL_CYCLES    = 20;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASES         = 6;
	localparam int RANDOM_PER_PHASE = 41;

	// Expected byte runs for the link, with the rotation that shapes them
	class byte_run_scoreboard;
		typedef struct packed {
			logic [7:0] value;
			logic       data;
			logic       last;
		} link_word_t;

		link_word_t due[$];
		logic [1:0] rotation = 2'd0;
		int errors = 0;

		function void put(logic [7:0] value, logic data);
			link_word_t w;
			w.value = value;
			w.data  = data;
			w.last  = 1'b0;
			due.push_back(w);
		endfunction

		// three 6-bit channel bytes from RGB565
		function void put_colour(logic [15:0] c);
			put({2'b00, c[15:11], 1'b0}, 1'b0);
			put({2'b00, c[10:5]}, 1'b0);
			put({2'b00, c[4:0], 1'b0}, 1'b0);
		endfunction

		function void put_corners(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d);
			put(a, 1'b0);
			put(b, 1'b0);
			put(c, 1'b0);
			put(d, 1'b0);
		endfunction

		function int pending();
			return due.size();
		endfunction

		// Work out the run of bytes that one accepted request produces
		function void note_request(logic [3:0] op, logic [7:0] sx, logic [7:0] sy,
				logic [7:0] ex, logic [7:0] ey, logic [15:0] c);
			logic [7:0] x0, y0, x1, y1;
			int first;
			link_word_t w;
			first = due.size();
			x0 = sx;
			y0 = sy;
			x1 = ex;
			y1 = ey;
			// odd quarter turns swap the axes
			if (rotation[0]) begin
				x0 = sy;
				y0 = sx;
				x1 = ey;
				y1 = ex;
			end
			case (op)
				OP_POINT: begin
					put(CMD_COL_ADDR, 1'b0);
					put(x0, 1'b0);
					put(COL_LAST, 1'b0);
					put(CMD_ROW_ADDR, 1'b0);
					put(y0, 1'b0);
					put(ROW_LAST, 1'b0);
					put(c[15:8], 1'b1);
					put(c[7:0], 1'b1);
				end
				OP_LINE: begin
					put(CMD_LINE, 1'b0);
					put_corners(x0, y0, x1, y1);
					put_colour(c);
				end
				OP_RECT, OP_FILL: begin
					put(CMD_FILL_EN, 1'b0);
					put({7'd0, op == OP_FILL}, 1'b0);
					put(CMD_RECT, 1'b0);
					put_corners(x0, y0, x1, y1);
					put_colour(c);
					put_colour(op == OP_FILL ? c : 16'd0);
				end
				OP_CLEAR: begin
					put(CMD_CLEAR, 1'b0);
					put_corners(8'd0, 8'd0, COL_LAST, ROW_LAST);
				end
				OP_ON: put(CMD_DISP_ON, 1'b0);
				OP_OFF: put(CMD_DISP_OFF, 1'b0);
				OP_WINDOW: begin
					// window ends wrap to eight bits
					put(CMD_COL_ADDR, 1'b0);
					put(x0, 1'b0);
					put(8'(x0 + COL_LAST), 1'b0);
					put(CMD_ROW_ADDR, 1'b0);
					put(y0, 1'b0);
					put(8'(y0 + ROW_LAST), 1'b0);
				end
				OP_PIXEL: begin
					put(c[15:8], 1'b1);
					put(c[7:0], 1'b1);
				end
				OP_REMAP: begin
					put(CMD_REMAP, 1'b0);
					case (rotation)
						2'd1: put(REMAP_ROT1, 1'b0);
						2'd2: put(REMAP_ROT2, 1'b0);
						2'd3: put(REMAP_ROT3, 1'b0);
						default: put(REMAP_ROT0, 1'b0);
					endcase
				end
				default: ;
			endcase
			if (due.size() > first) begin
				w = due.pop_back();
				w.last = 1'b1;
				due.push_back(w);
			end
		endfunction

		// Compare one word taken from the link with the oldest expectation
		function void check_byte(logic [7:0] value, logic data, logic last);
			link_word_t w;
			if (due.size() == 0) begin
				$error("unexpected word: out_byte %h is_data %b last_byte %b", value, data, last);
				errors++;
				return;
			end
			w = due.pop_front();
			if (value !== w.value) begin
				$error("out_byte: expected %h, got %h", w.value, value);
				errors++;
			end
			if (data !== w.data) begin
				$error("is_data: expected %b, got %b", w.data, data);
				errors++;
			end
			if (last !== w.last) begin
				$error("last_byte: expected %b, got %b", w.last, last);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wen = 1'b0;
	logic [1:0]  cfg_wdata = 2'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [3:0]  opcode = 4'd0;
	logic [7:0]  start_x = 8'd0;
	logic [7:0]  start_y = 8'd0;
	logic [7:0]  end_x = 8'd0;
	logic [7:0]  end_y = 8'd0;
	logic [15:0] pixel_color = 16'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        is_data;
	logic        last_byte;

	byte_run_scoreboard sb = new;
	bit sender_idles = 1'b0;
	bit receiver_idles = 1'b0;
	bit hold_out = 1'b0;
	int quiet_cycles = 0;
	int rot_order[4] = '{1, 3, 2, 0};

	oled_draw_command_formatter_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.pixel_color(pixel_color),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.is_data    (is_data),
		.last_byte  (last_byte)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Watch both channels; note requests, check words, time out when stuck
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_request(opcode, start_x, start_y, end_x, end_y, pixel_color);
		if (arst_n && out_valid && out_ready)
			sb.check_byte(out_byte, is_data, last_byte);
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Receiver: random stalls per word, and one long hold-off on request
	initial begin : receiver
		int stall;
		@(posedge clk);
		forever begin
			if (hold_out) begin
				hold_out = 1'b0;
				stall = HOLD_CYCLES;
			end else begin
				stall = receiver_idles ? $urandom_range(0, MAX_WAIT) : 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Offer one request and hold it until taken; valid stays up on return
	task automatic send_request(input logic [3:0] op, input logic [7:0] sx,
			input logic [7:0] sy, input logic [7:0] ex, input logic [7:0] ey,
			input logic [15:0] c);
		int gap;
		gap = sender_idles ? $urandom_range(0, MAX_WAIT) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		start_x     <= sx;
		start_y     <= sy;
		end_x       <= ex;
		end_y       <= ey;
		pixel_color <= c;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_random();
		logic [3:0] op;
		// mostly real drawing requests, a few unused opcodes
		if ($urandom_range(0, 9) == 0)
			op = 4'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
		else
			op = 4'($urandom_range(OP_POINT, OP_REMAP));
		send_request(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			16'($urandom));
	endtask

	// Wait until every expected word has come and the block has gone quiet
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic set_rotation(input logic [1:0] rot);
		cfg_wdata <= rot;
		cfg_wen   <= 1'b1;
		@(posedge clk);
		cfg_wen <= 1'b0;
		sb.rotation = rot;
	endtask

	initial begin : stimulus
		// falling edge on the reset line at time zero
		arst_n <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests at reset rotation: field extremes, every opcode, wraps
		sender_idles   = 1'b1;
		receiver_idles = 1'b1;
		send_request(OP_POINT, 8'hFF, 8'hFF, 8'h00, 8'h00, 16'hFFFF);
		send_request(OP_POINT, 8'h00, 8'h00, 8'hFF, 8'hFF, 16'h0000);
		send_request(OP_LINE, 8'h00, 8'h00, 8'hFF, 8'hFF, 16'hF800);
		send_request(OP_LINE, 8'hFF, 8'h00, 8'h00, 8'hFF, 16'h07E0);
		send_request(OP_LINE, 8'h55, 8'hAA, 8'hAA, 8'h55, 16'h5555);
		send_request(OP_RECT, 8'h01, 8'h02, 8'hC8, 8'h64, 16'h001F);
		send_request(OP_RECT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
		send_request(OP_FILL, 8'hFF, 8'hFF, 8'h00, 8'h00, 16'hFFFF);
		send_request(OP_FILL, 8'h10, 8'h20, 8'h30, 8'h40, 16'hAAAA);
		send_request(OP_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
		send_request(OP_ON, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);
		send_request(OP_OFF, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);
		send_request(OP_WINDOW, 8'hFF, 8'hFF, 8'h00, 8'h00, 16'h0000);
		send_request(OP_WINDOW, 8'h00, 8'h00, 8'hFF, 8'hFF, 16'hFFFF);
		send_request(OP_WINDOW, 8'hA0, 8'hC0, 8'h00, 8'h00, 16'h0000);
		send_request(OP_WINDOW, 8'hA1, 8'hC1, 8'h00, 8'h00, 16'h0000);
		send_request(OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 16'hFFFF);
		send_request(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hA5A5);
		send_request(OP_REMAP, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);
		send_request(OP_UNUSED_FIRST, 8'h12, 8'h34, 8'h56, 8'h78, 16'h9ABC);
		send_request(OP_UNUSED_LAST, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
		send_request(OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);

		// Random phases, each setting a rotation and an idling mix
		for (int p = 0; p < PHASES; p++) begin
			drain();
			set_rotation(p < 4 ? 2'(rot_order[p]) : 2'($urandom_range(0, 3)));
			sender_idles   = p[0];
			receiver_idles = p[1];
			send_request(OP_REMAP, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);
			send_request(OP_LINE, 8'h01, 8'h02, 8'h03, 8'h04, 16'h1234);
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				// back-pressure burst while the sender keeps offering
				if (p == 0 && i == 5)
					hold_out = 1'b1;
				send_random();
			end
		end
		drain();

		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
